// File: rtl/core/pfct_pkg.sv
package pfct_pkg;

   localparam logic [15:0] ETHER_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP  = 8'd6;
   localparam logic [7:0]  PROTO_UDP  = 8'd17;

   localparam logic [15:0] HTTP_PORT_RESET = 16'd80;
   localparam logic [15:0] DNS_PORT_RESET  = 16'd53;

   localparam logic REQ_PACKET  = 1'b0;
   localparam logic REQ_COUNTER = 1'b1;

   localparam int STAT_COUNT = 6;
   localparam logic [2:0] CNT_PACKETS = 3'd0;
   localparam logic [2:0] CNT_BYTES   = 3'd1;
   localparam logic [2:0] CNT_TCP     = 3'd2;
   localparam logic [2:0] CNT_UDP     = 3'd3;
   localparam logic [2:0] CNT_HTTP    = 3'd4;
   localparam logic [2:0] CNT_DNS     = 3'd5;

   localparam logic [1:0] TRANSPORT_OTHER = 2'd0;
   localparam logic [1:0] TRANSPORT_TCP   = 2'd1;
   localparam logic [1:0] TRANSPORT_UDP   = 2'd2;

   localparam logic [1:0] APP_NONE = 2'd0;
   localparam logic [1:0] APP_HTTP = 2'd1;
   localparam logic [1:0] APP_DNS  = 2'd2;

   localparam logic [1:0] FLOW_NONE   = 2'd0;
   localparam logic [1:0] FLOW_HIT    = 2'd1;
   localparam logic [1:0] FLOW_INSERT = 2'd2;
   localparam logic [1:0] FLOW_FULL   = 2'd3;

   localparam logic ADDR_HTTP_PORT = 1'b0;
   localparam logic ADDR_DNS_PORT  = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [15:0] wire_len;
      logic [15:0] eth_type;
      logic [7:0]  ip_protocol;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port_in;
      logic [15:0] dst_port_in;
      logic        syn_flag;
      logic        ack_flag;
      logic [2:0]  counter_select;
   } req_data_type;

   typedef struct packed {
      logic [63:0] packet_number;
      logic        is_ipv4;
      logic [1:0]  transport;
      logic [1:0]  app_class;
      logic        syn_alert;
      logic [1:0]  flow_status;
      logic [5:0]  flow_slot;
      logic [63:0] counter_value;
   } rsp_data_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
   } flow_key_type;

   typedef struct packed {
      logic       done;
      logic [1:0] status;
      logic [5:0] slot;
   } flow_res_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] wire_len;
      logic        tcp;
      logic        udp;
      logic        http;
      logic        dns;
   } stat_upd_type;

endpackage

// File: rtl/core/pfct_stats.sv
module pfct_stats
   import pfct_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  stat_upd_type upd,
   input  logic [2:0]   sel,
   output logic [63:0]  sel_value,
   output logic [63:0]  pkt_count
);

   logic [63:0] cnt_ff [STAT_COUNT];
   logic [63:0] cnt_in [STAT_COUNT];

   always_comb begin
      for (int i = 0; i < STAT_COUNT; i++) begin
         cnt_in[i] = cnt_ff[i];
      end
      if (upd.valid) begin
         cnt_in[CNT_PACKETS] = cnt_ff[CNT_PACKETS] + 64'd1;
         cnt_in[CNT_BYTES]   = cnt_ff[CNT_BYTES] + {48'd0, upd.wire_len};
         if (upd.tcp) begin
            cnt_in[CNT_TCP] = cnt_ff[CNT_TCP] + 64'd1;
         end
         if (upd.udp) begin
            cnt_in[CNT_UDP] = cnt_ff[CNT_UDP] + 64'd1;
         end
         if (upd.http) begin
            cnt_in[CNT_HTTP] = cnt_ff[CNT_HTTP] + 64'd1;
         end
         if (upd.dns) begin
            cnt_in[CNT_DNS] = cnt_ff[CNT_DNS] + 64'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < STAT_COUNT; i++) begin
         if (reset) begin
            cnt_ff[i] <= '0;
         end else begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   always_comb begin
      unique case (sel)
         CNT_PACKETS: sel_value = cnt_ff[CNT_PACKETS];
         CNT_BYTES:   sel_value = cnt_ff[CNT_BYTES];
         CNT_TCP:     sel_value = cnt_ff[CNT_TCP];
         CNT_UDP:     sel_value = cnt_ff[CNT_UDP];
         CNT_HTTP:    sel_value = cnt_ff[CNT_HTTP];
         CNT_DNS:     sel_value = cnt_ff[CNT_DNS];
         default:     sel_value = '0;
      endcase
   end

   assign pkt_count = cnt_ff[CNT_PACKETS];

endmodule

// File: rtl/core/pfct_flow_table.sv
module pfct_flow_table
   import pfct_pkg::*;
#(
   parameter int FLOW_ENTRIES = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  flow_key_type key,
   output flow_res_type res
);

   localparam int IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
   localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);
   localparam logic [CNT_W-1:0] ENTRIES_C = CNT_W'(FLOW_ENTRIES);

   typedef enum logic {
      ST_IDLE,
      ST_SEARCH
   } state_type;

   flow_key_type mem [FLOW_ENTRIES];
   flow_key_type rd_data_ff;

   state_type        state_ff, state_in;
   flow_key_type     key_ff, key_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic             rd_vld_ff, rd_vld_in;
   flow_res_type     res_ff, res_in;
   logic             wr_en;
   logic [IDX_W-1:0] slot_idx;
   logic [IDX_W+5:0] slot_ext;

   assign slot_ext = {6'd0, slot_idx};

   always_comb begin
      state_in   = state_ff;
      key_in     = key_ff;
      cnt_in     = cnt_ff;
      used_in    = used_ff;
      hit_idx_in = hit_idx_ff;
      rd_vld_in  = 1'b0;
      res_in     = res_ff;
      res_in.done = 1'b0;
      wr_en      = 1'b0;
      slot_idx   = hit_idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in   = key;
               cnt_in   = '0;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            priority if (rd_vld_ff && (rd_data_ff == key_ff)) begin
               res_in.done   = 1'b1;
               res_in.status = FLOW_HIT;
               res_in.slot   = slot_ext[5:0];
               state_in      = ST_IDLE;
            end else if (cnt_ff < used_ff) begin
               hit_idx_in = cnt_ff[IDX_W-1:0];
               cnt_in     = cnt_ff + 1'b1;
               rd_vld_in  = 1'b1;
            end else if (used_ff == ENTRIES_C) begin
               res_in.done   = 1'b1;
               res_in.status = FLOW_FULL;
               res_in.slot   = '0;
               state_in      = ST_IDLE;
            end else begin
               wr_en         = 1'b1;
               slot_idx      = used_ff[IDX_W-1:0];
               used_in       = used_ff + 1'b1;
               res_in.done   = 1'b1;
               res_in.status = FLOW_INSERT;
               res_in.slot   = slot_ext[5:0];
               state_in      = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         used_ff   <= '0;
         rd_vld_ff <= 1'b0;
         res_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         used_ff   <= used_in;
         rd_vld_ff <= rd_vld_in;
         res_ff    <= res_in;
      end
      key_ff     <= key_in;
      cnt_ff     <= cnt_in;
      hit_idx_ff <= hit_idx_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[used_ff[IDX_W-1:0]] <= key_ff;
      end
      rd_data_ff <= mem[cnt_ff[IDX_W-1:0]];
   end

   assign res = res_ff;

endmodule

// File: rtl/core/packet_classifier_flow_tracker_top.sv
// channel   | direction | handshake            | payload
// request   | in        | req_valid/req_stall  | req_data (req_data_type)
// response  | out       | rsp_valid/rsp_stall  | rsp_data (rsp_data_type)
// registers | in/out    | psel/penable/pready  | paddr, pwdata, prdata
//
// A counter read passes the dispatch and done states; a packet without a tracked
// flow passes dispatch, stats and done. A TCP or UDP packet adds the flow lookup
// after dispatch, which on a miss scans all filled flow slots and on a hit stops
// at the matching slot: the flow memory has one read port and the search checks
// one slot per cycle. One request is in work at a time; the next request is taken
// while the finished response waits under rsp_stall. Reset is synchronous;
// counters, fill count and registers clear at once, the flow memory is not swept.
module packet_classifier_flow_tracker_top
   import pfct_pkg::*;
#(
   parameter int FLOW_ENTRIES = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_data_type rsp_data,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_LOOKUP,
      ST_STATS,
      ST_DONE
   } state_type;

   state_type    state_ff, state_in;
   req_data_type req_ff, req_in;
   logic [1:0]   status_ff, status_in;
   logic [5:0]   slot_ff, slot_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_ff, rsp_in;
   logic [15:0]  http_port_ff, http_port_in;
   logic [15:0]  dns_port_ff, dns_port_in;

   logic         is_ipv4, is_tcp, is_udp, is_http, is_dns, alert;
   flow_key_type key;
   flow_res_type flow_res;
   logic         flow_start;
   stat_upd_type upd;
   logic [63:0]  sel_value, pkt_count;
   logic         csr_write;

   assign is_ipv4 = (req_ff.eth_type == ETHER_IPV4);
   assign is_tcp  = is_ipv4 && (req_ff.ip_protocol == PROTO_TCP);
   assign is_udp  = is_ipv4 && (req_ff.ip_protocol == PROTO_UDP);
   assign is_http = is_tcp && ((req_ff.src_port_in == http_port_ff) ||
                               (req_ff.dst_port_in == http_port_ff));
   assign is_dns  = is_udp && ((req_ff.src_port_in == dns_port_ff) ||
                               (req_ff.dst_port_in == dns_port_ff));
   assign alert   = is_tcp && req_ff.syn_flag && !req_ff.ack_flag;

   assign key.kind     = is_udp;
   assign key.sport    = req_ff.src_port_in;
   assign key.dport    = req_ff.dst_port_in;
   assign key.src_addr = req_ff.src_addr;
   assign key.dst_addr = req_ff.dst_addr;

   assign flow_start = (state_ff == ST_DISPATCH) && (req_ff.req_type == REQ_PACKET) &&
                       (is_tcp || is_udp);

   assign upd.valid    = (state_ff == ST_STATS);
   assign upd.wire_len = req_ff.wire_len;
   assign upd.tcp      = is_tcp;
   assign upd.udp      = is_udp;
   assign upd.http     = is_http;
   assign upd.dns      = is_dns;

   pfct_flow_table #(
      .FLOW_ENTRIES(FLOW_ENTRIES)
   ) u_flow_table (
      .clock(clock),
      .reset(reset),
      .start(flow_start),
      .key  (key),
      .res  (flow_res)
   );

   pfct_stats u_stats (
      .clock    (clock),
      .reset    (reset),
      .upd      (upd),
      .sel      (req_ff.counter_select),
      .sel_value(sel_value),
      .pkt_count(pkt_count)
   );

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      status_in    = status_ff;
      slot_in      = slot_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            status_in = FLOW_NONE;
            slot_in   = '0;
            priority if (req_ff.req_type == REQ_COUNTER) begin
               state_in = ST_DONE;
            end else if (flow_start) begin
               state_in = ST_LOOKUP;
            end else begin
               state_in = ST_STATS;
            end
         end
         ST_LOOKUP: begin
            if (flow_res.done) begin
               status_in = flow_res.status;
               slot_in   = flow_res.slot;
               state_in  = ST_STATS;
            end
         end
         ST_STATS: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in = '0;
               if (req_ff.req_type == REQ_COUNTER) begin
                  rsp_in.counter_value = sel_value;
               end else begin
                  rsp_in.packet_number = pkt_count;
                  rsp_in.is_ipv4       = is_ipv4;
                  rsp_in.transport     = is_tcp ? TRANSPORT_TCP :
                                         (is_udp ? TRANSPORT_UDP : TRANSPORT_OTHER);
                  rsp_in.app_class     = is_http ? APP_HTTP :
                                         (is_dns ? APP_DNS : APP_NONE);
                  rsp_in.syn_alert     = alert;
                  rsp_in.flow_status   = status_ff;
                  rsp_in.flow_slot     = slot_ff;
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign csr_write = psel && penable && pwrite;

   always_comb begin
      http_port_in = http_port_ff;
      dns_port_in  = dns_port_ff;
      if (csr_write) begin
         unique case (paddr[2])
            ADDR_HTTP_PORT: http_port_in = pwdata[15:0];
            ADDR_DNS_PORT:  dns_port_in  = pwdata[15:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         http_port_ff <= HTTP_PORT_RESET;
         dns_port_ff  <= DNS_PORT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         http_port_ff <= http_port_in;
         dns_port_ff  <= dns_port_in;
      end
      req_ff    <= req_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
      rsp_ff    <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == ADDR_DNS_PORT) ? {16'd0, dns_port_ff} :
                                                    {16'd0, http_port_ff};

endmodule

// File: rtl/core/pfct_checker.sv
module pfct_checker
   import pfct_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_data_type rsp_data,
   input logic         pready
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // block one request at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   a_counter_read_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.counter_value != 64'd0) |->
         (rsp_data.packet_number == 64'd0) && (rsp_data.flow_status == FLOW_NONE) &&
         !rsp_data.is_ipv4)
      else $error("counter read response carries packet fields");

   a_untracked_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.transport == TRANSPORT_OTHER) |->
         (rsp_data.flow_status == FLOW_NONE) && (rsp_data.app_class == APP_NONE) &&
         !rsp_data.syn_alert && (rsp_data.flow_slot == 6'd0))
      else $error("untracked packet carries flow fields");

   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready low");

endmodule

bind packet_classifier_flow_tracker_top pfct_checker u_pfct_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data),
   .pready   (pready)
);
